### design/particle_pool_engine_defines.svh
// assertion macros shared by the particle pool engine modules
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PARTICLE_POOL_ENGINE_DEFINES_SVH
`define PARTICLE_POOL_ENGINE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PPE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ppe: invariant violated");

// pre at one edge implies post at the next
`define PPE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ppe: sequence violated");

`endif

### design/ppe_pkg.sv
// shared types, codes and helper functions of the particle pool engine
// no dependencies
package ppe_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int SLOT_W    = $clog2(POOL_SIZE);

    localparam logic [1:0] OP_EMIT = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] CFG_VJX    = 3'd0;
    localparam logic [2:0] CFG_VJY    = 3'd1;
    localparam logic [2:0] CFG_SJ     = 3'd2;
    localparam logic [2:0] CFG_SSIZE  = 3'd3;
    localparam logic [2:0] CFG_FSIZE  = 3'd4;
    localparam logic [2:0] CFG_SCOL   = 3'd5;
    localparam logic [2:0] CFG_FCOL   = 3'd6;
    localparam logic [2:0] CFG_LIFE   = 3'd7;

    localparam logic [1:0] OUT_ZERO   = 2'd0;
    localparam logic [1:0] OUT_RANGE  = 2'd1;
    localparam logic [1:0] OUT_RENDER = 2'd2;

    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
    localparam logic [16:0] FRAC_ONE   = 17'd65536;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        delta_time;
        logic [15:0]        rnd_rotation;
        logic [15:0]        rnd_vel_x;
        logic [15:0]        rnd_vel_y;
        logic [15:0]        rnd_size;
        logic [9:0]         read_slot;
    } t_in;

    typedef struct packed {
        logic [9:0]         slot_index;
        logic               slot_active;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_rotation;
        logic [30:0]        out_size;
        logic [31:0]        out_colour;
    } t_out;

    typedef struct packed {
        logic               live;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rot;
        logic signed [31:0] rem;
        logic [30:0]        full;
        logic [30:0]        bsize;
        logic [30:0]        dsize;
        logic [31:0]        bcol;
        logic [31:0]        dcol;
    } t_slot;

    typedef struct packed {
        logic              capture;
        logic              emit_mul;
        logic              emit_wr;
        logic              rd_en;
        logic              tick_issue;
        logic [SLOT_W-1:0] tick_addr;
        logic              div_start;
        logic              mix;
        logic              out_load;
        logic [1:0]        out_mode;
    } t_cmd;

    typedef struct packed {
        logic range_bad;
        logic pipe_busy;
        logic div_busy;
    } t_stat;

    function automatic logic signed [31:0] sat_s32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -49'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // span times a centred fraction, floored to q16.16
    function automatic logic signed [31:0] jitter(input logic [30:0] span,
                                                  input logic [15:0] rnd);
        logic signed [15:0] centred;
        logic signed [47:0] p;
        centred = {~rnd[15], rnd[14:0]};
        p = $signed({1'b0, span}) * centred;
        return p[47:16];
    endfunction

endpackage

### design/ppe_divider.sv
// restoring divider for the life fraction, one quotient bit per cycle
// depends on ppe_pkg
module ppe_divider
    import ppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_quot
);

    logic [31:0] r_rem, n_rem;
    logic [15:0] r_quot, n_quot;
    logic [4:0]  r_cnt, n_cnt;
    logic [30:0] r_den;
    logic [31:0] shifted;

    assign shifted = {r_rem[30:0], 1'b0};

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_rem  = {1'b0, i_num};
            n_quot = '0;
            n_cnt  = 5'd16;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 5'd1;
            if (shifted >= {1'b0, r_den}) begin
                n_rem  = shifted - {1'b0, r_den};
                n_quot = {r_quot[14:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_quot = {r_quot[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

### design/ppe_ctrl.sv
// controller state machine: sequences emit, tick walk and read render
// depends on ppe_pkg and the assertion macros header
`include "particle_pool_engine_defines.svh"
module ppe_ctrl
    import ppe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EM_MUL   = 4'd1;
    localparam logic [3:0] S_EM_WR    = 4'd2;
    localparam logic [3:0] S_RD_ISSUE = 4'd3;
    localparam logic [3:0] S_RD_DATA  = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_MIX1     = 4'd6;
    localparam logic [3:0] S_MIX2     = 4'd7;
    localparam logic [3:0] S_TICK     = 4'd8;
    localparam logic [3:0] S_DRAIN    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.tick_addr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    case (i_op)
                        OP_EMIT: n_state = S_EM_MUL;
                        OP_TICK: n_state = S_TICK;
                        OP_READ: n_state = S_RD_ISSUE;
                        default: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_mode = OUT_ZERO;
                        end
                    endcase
                end
            end
            S_EM_MUL: begin
                o_cmd.emit_mul = 1'b1;
                n_state = S_EM_WR;
            end
            S_EM_WR: begin
                o_cmd.emit_wr = 1'b1;
                n_state = S_RD_ISSUE;
            end
            S_RD_ISSUE: begin
                if (i_stat.range_bad) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mode = OUT_RANGE;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MIX1;
                end
            end
            S_MIX1: begin
                o_cmd.mix = 1'b1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_mode = OUT_RENDER;
                n_state = S_IDLE;
            end
            S_TICK: begin
                o_cmd.tick_issue = 1'b1;
                if (r_cnt == SLOT_W'(POOL_SIZE - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mode = OUT_ZERO;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `PPE_ASSERT_NEXT(a_div_to_mix, (r_state == S_DIV) && !i_stat.div_busy, r_state == S_MIX1)
    `PPE_ASSERT_ALWAYS(a_cnt_outside_walk, (r_state == S_TICK) || (r_cnt == '0))

endmodule

### design/ppe_datapath.sv
// datapath: config registers, slot memory, emit maths, tick pipeline, render
// depends on ppe_pkg, ppe_divider and the assertion macros header
`include "particle_pool_engine_defines.svh"
module ppe_datapath
    import ppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_in         i_item,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_out        o_result,
    output logic        o_strobe
);

    // configuration
    logic [30:0] r_vjx, r_vjy, r_sj, r_ssize, r_fsize, r_life;
    logic [31:0] r_scol, r_fcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vjx   <= '0;
            r_vjy   <= '0;
            r_sj    <= '0;
            r_ssize <= 31'd32768;
            r_fsize <= '0;
            r_scol  <= 32'hffffffff;
            r_fcol  <= '0;
            r_life  <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VJX:   r_vjx   <= i_cfg_data[30:0];
                CFG_VJY:   r_vjy   <= i_cfg_data[30:0];
                CFG_SJ:    r_sj    <= i_cfg_data[30:0];
                CFG_SSIZE: r_ssize <= i_cfg_data[30:0];
                CFG_FSIZE: r_fsize <= i_cfg_data[30:0];
                CFG_SCOL:  r_scol  <= i_cfg_data;
                CFG_FCOL:  r_fcol  <= i_cfg_data;
                CFG_LIFE:  r_life  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // captured item and ring state
    t_in               r_in;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_next_slot;
    logic              r_wrapped;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in   <= i_item;
            r_slot <= (i_item.op == OP_EMIT) ? r_next_slot : i_item.read_slot[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= SLOT_W'(POOL_SIZE - 1);
            r_wrapped   <= 1'b0;
        end else if (i_cmd.emit_wr) begin
            if (r_next_slot == '0) begin
                r_next_slot <= SLOT_W'(POOL_SIZE - 1);
                r_wrapped   <= 1'b1;
            end else begin
                r_next_slot <= r_next_slot - 1'b1;
            end
        end
    end

    assign o_stat.range_bad = (r_in.op == OP_READ) &&
                              ({1'b0, r_in.read_slot} >= 11'(POOL_SIZE));

    // emit: products first, then saturate and write
    logic signed [31:0] r_jx, r_jy, r_js;
    logic [18:0]        r_rot0;
    logic [34:0]        rot_prod;

    assign rot_prod = 35'(r_in.rnd_rotation) * 35'(TWO_PI_Q16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_mul) begin
            r_jx   <= jitter(r_vjx, r_in.rnd_vel_x);
            r_jy   <= jitter(r_vjy, r_in.rnd_vel_y);
            r_js   <= jitter(r_sj, r_in.rnd_size);
            r_rot0 <= rot_prod[34:16];
        end
    end

    t_slot              emit_word;
    logic signed [48:0] size_sum;

    always_comb begin
        size_sum        = 49'($signed({1'b0, r_ssize})) + 49'(r_js);
        emit_word       = '0;
        emit_word.live  = 1'b1;
        emit_word.pos_x = r_in.pos_x;
        emit_word.pos_y = r_in.pos_y;
        emit_word.vel_x = sat_s32(49'(r_in.vel_x) + 49'(r_jx));
        emit_word.vel_y = sat_s32(49'(r_in.vel_y) + 49'(r_jy));
        emit_word.rot   = $signed({13'd0, r_rot0});
        emit_word.rem   = $signed({1'b0, r_life});
        emit_word.full  = r_life;
        if (size_sum < 49'sd0) begin
            emit_word.bsize = '0;
        end else if (size_sum > 49'sd2147483647) begin
            emit_word.bsize = 31'h7fffffff;
        end else begin
            emit_word.bsize = size_sum[30:0];
        end
        emit_word.dsize = r_fsize;
        emit_word.bcol  = r_scol;
        emit_word.dcol  = r_fcol;
    end

    // slot memory, one write and one registered read a cycle
    t_slot             mem [POOL_SIZE];
    t_slot             r_rd_data;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_wa, mem_ra;
    t_slot             mem_wd, tick_word;

    // tick pipeline: read, multiply, write back
    logic               r_v1, r_v2;
    logic [SLOT_W-1:0]  r_s1, r_s2;
    logic               r_ret2;
    t_slot              r_w2;
    logic signed [63:0] r_px, r_py;
    logic signed [31:0] dt_s, rot_inc;
    logic signed [63:0] prod_x, prod_y;
    logic               live1, retire1;
    logic signed [47:0] step_x, step_y;

    assign mem_re = i_cmd.rd_en | i_cmd.tick_issue;
    assign mem_ra = i_cmd.tick_issue ? i_cmd.tick_addr : r_slot;
    assign mem_we = i_cmd.emit_wr | r_v2;
    assign mem_wa = i_cmd.emit_wr ? r_next_slot : r_s2;
    assign mem_wd = i_cmd.emit_wr ? emit_word : tick_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign dt_s    = $signed({1'b0, r_in.delta_time});
    // 100 * dt as shifts, wrapping
    assign rot_inc = (dt_s <<< 6) + (dt_s <<< 5) + (dt_s <<< 2);
    assign prod_x  = r_rd_data.vel_x * dt_s;
    assign prod_y  = r_rd_data.vel_y * dt_s;
    // a slot at or below the ring index has not been emitted since reset, unless the ring has wrapped
    assign live1   = r_rd_data.live & (r_wrapped | (r_s1 > r_next_slot));
    assign retire1 = live1 & (r_rd_data.rem <= 32'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tick_issue;
            r_v2 <= r_v1 & live1;
        end
        r_s1   <= i_cmd.tick_addr;
        r_s2   <= r_s1;
        r_ret2 <= retire1;
        r_w2   <= r_rd_data;
        r_px   <= prod_x;
        r_py   <= prod_y;
    end

    assign step_x = r_px[63:16];
    assign step_y = r_py[63:16];

    always_comb begin
        tick_word = r_w2;
        if (r_ret2) begin
            tick_word.live = 1'b0;
        end else begin
            tick_word.rem   = r_w2.rem - dt_s;
            tick_word.pos_x = sat_s32(49'(r_w2.pos_x) + 49'(step_x));
            tick_word.pos_y = sat_s32(49'(r_w2.pos_y) + 49'(step_y));
            tick_word.rot   = r_w2.rot + rot_inc;
        end
    end

    assign o_stat.pipe_busy = r_v1 | r_v2;

    // render: life fraction, then interpolation
    logic [15:0] quot;
    logic        div_busy;

    ppe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rd_data.rem[30:0]),
        .i_den   (r_rd_data.full),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign o_stat.div_busy = div_busy;

    logic [16:0] frac, frac_inv;
    logic        r_act;
    logic [47:0] r_ms_e, r_ms_b;
    logic [24:0] r_mc_e [4];
    logic [24:0] r_mc_b [4];

    always_comb begin
        if (r_rd_data.rem <= 32'sd0) begin
            frac = '0;
        end else if (r_rd_data.rem >= $signed({1'b0, r_rd_data.full})) begin
            frac = FRAC_ONE;
        end else begin
            frac = {1'b0, quot};
        end
        frac_inv = FRAC_ONE - frac;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_act  <= r_rd_data.live & (r_wrapped | (r_slot > r_next_slot));
            r_ms_e <= 48'(r_rd_data.dsize) * 48'(frac_inv);
            r_ms_b <= 48'(r_rd_data.bsize) * 48'(frac);
            for (int b = 0; b < 4; b++) begin
                r_mc_e[b] <= 25'(r_rd_data.dcol[8*b +: 8]) * 25'(frac_inv);
                r_mc_b[b] <= 25'(r_rd_data.bcol[8*b +: 8]) * 25'(frac);
            end
        end
    end

    logic [48:0] size_mix;
    logic [25:0] col_mix [4];
    logic [31:0] colour;

    always_comb begin
        size_mix = 49'(r_ms_e) + 49'(r_ms_b) + 49'd32768;
        for (int b = 0; b < 4; b++) begin
            col_mix[b] = 26'(r_mc_e[b]) + 26'(r_mc_b[b]) + 26'd32768;
            colour[8*b +: 8] = col_mix[b][23:16];
        end
    end

    // result register, one beat per load
    t_out r_out, n_out;
    logic r_strobe;

    always_comb begin
        n_out = '0;
        unique case (i_cmd.out_mode)
            OUT_RANGE: n_out.slot_index = r_in.read_slot;
            OUT_RENDER: begin
                n_out.slot_index   = 10'(r_slot);
                n_out.slot_active  = r_act;
                n_out.out_pos_x    = r_rd_data.pos_x;
                n_out.out_pos_y    = r_rd_data.pos_y;
                n_out.out_rotation = r_rd_data.rot;
                n_out.out_size     = size_mix[46:16];
                n_out.out_colour   = colour;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_load;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    `PPE_ASSERT_ALWAYS(a_single_writer, !(i_cmd.emit_wr && r_v2))
    `PPE_ASSERT_ALWAYS(a_ring_in_range, r_next_slot <= SLOT_W'(POOL_SIZE - 1))

endmodule

### design/particle_pool_engine.sv
// particle pool engine top level: controller plus datapath
// depends on ppe_pkg, ppe_ctrl, ppe_datapath
//
//  channel   signals                         beat
//  item in   start, busy, i_item             start high while busy low
//  result    o_strobe, o_result              o_strobe high, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data i_cfg_we high
//
// emit: result after the accepting edge through multiply, write, read, the bit-serial
// fraction divide, the mix and the result load
// read: read, the same divide, mix and load; out of range: no read or divide; undefined op: zero
// tick: result after every slot is walked and the tick pipeline drains; one read per slot
// busy drops with the result; it cannot be stalled
// synchronous active-low reset; no clearing pass, slots never emitted read as idle
module particle_pool_engine
    import ppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output t_out        o_result
);

    t_cmd  cmd;
    t_stat stat;

    ppe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ppe_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the particle pool engine: directed and random items
// with a slot-level predictor of the whole pool; depends on ppe_pkg and particle_pool_engine
module testbench
    import ppe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNDEF  = 2'd3;
    localparam int         CYCLE_CAP = 3000000;
    localparam longint     MASK31    = 64'h7fffffff;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_strobe;
    t_out        o_result;

    particle_pool_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // predicted pool
    logic   slot_live [POOL_SIZE];
    logic   slot_written [POOL_SIZE];
    longint slot_px [POOL_SIZE];
    longint slot_py [POOL_SIZE];
    longint slot_vx [POOL_SIZE];
    longint slot_vy [POOL_SIZE];
    longint slot_rot [POOL_SIZE];
    longint slot_rem [POOL_SIZE];
    longint slot_full [POOL_SIZE];
    longint slot_bsize [POOL_SIZE];
    longint slot_dsize [POOL_SIZE];
    logic [31:0] slot_bcol [POOL_SIZE];
    logic [31:0] slot_dcol [POOL_SIZE];
    int     ring_slot;
    int     last_emitted;
    logic [31:0] reg_val [8];

    t_out   expected_results[$];
    int     fail_count;
    int     cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint spread(logic [30:0] span, logic [15:0] rnd);
        return (longint'(span) * (longint'(rnd) - 32768)) >>> 16;
    endfunction

    function automatic longint blend(longint e, longint b, longint f);
        return (e * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    function automatic t_out render_slot(int s);
        t_out   r;
        longint f;
        r = '0;
        if (slot_rem[s] <= 0) f = 0;
        else if (slot_rem[s] >= slot_full[s]) f = 65536;
        else f = (slot_rem[s] <<< 16) / slot_full[s];
        for (int b = 0; b < 32; b += 8) begin
            r.out_colour[b +: 8] = 8'(blend(longint'(slot_dcol[s][b +: 8]),
                                             longint'(slot_bcol[s][b +: 8]), f));
        end
        r.slot_index   = 10'(s);
        r.slot_active  = slot_live[s];
        r.out_pos_x    = slot_px[s][31:0];
        r.out_pos_y    = slot_py[s][31:0];
        r.out_rotation = slot_rot[s][31:0];
        r.out_size     = 31'(blend(slot_dsize[s], slot_bsize[s], f) & MASK31);
        return r;
    endfunction

    // advances the predicted pool by one item and gives its result
    function automatic t_out pool_result(t_in it);
        t_out   r;
        longint sz;
        longint dt;
        int     s;
        r = '0;
        case (it.op)
            OP_EMIT: begin
                s = ring_slot;
                slot_live[s]    = 1'b1;
                slot_written[s] = 1'b1;
                slot_px[s]  = longint'(it.pos_x);
                slot_py[s]  = longint'(it.pos_y);
                slot_rot[s] = (longint'(it.rnd_rotation) * 411775) >>> 16;
                slot_vx[s]  = clamp_s32(longint'(it.vel_x) + spread(reg_val[CFG_VJX][30:0],
                                                                    it.rnd_vel_x));
                slot_vy[s]  = clamp_s32(longint'(it.vel_y) + spread(reg_val[CFG_VJY][30:0],
                                                                    it.rnd_vel_y));
                slot_bcol[s] = reg_val[CFG_SCOL];
                slot_dcol[s] = reg_val[CFG_FCOL];
                slot_full[s] = longint'(reg_val[CFG_LIFE][30:0]);
                slot_rem[s]  = slot_full[s];
                sz = longint'(reg_val[CFG_SSIZE][30:0])
                     + spread(reg_val[CFG_SJ][30:0], it.rnd_size);
                if (sz < 0) sz = 0;
                if (sz > MASK31) sz = MASK31;
                slot_bsize[s] = sz;
                slot_dsize[s] = longint'(reg_val[CFG_FSIZE][30:0]);
                ring_slot    = (s == 0) ? POOL_SIZE - 1 : s - 1;
                last_emitted = s;
                r = render_slot(s);
            end
            OP_TICK: begin
                dt = longint'(it.delta_time);
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (!slot_live[i]) continue;
                    if (slot_rem[i] <= 0) begin
                        slot_live[i] = 1'b0;
                        continue;
                    end
                    slot_rem[i] -= dt;
                    slot_px[i] = clamp_s32(slot_px[i] + ((slot_vx[i] * dt) >>> 16));
                    slot_py[i] = clamp_s32(slot_py[i] + ((slot_vy[i] * dt) >>> 16));
                    slot_rot[i] = longint'($signed(32'(slot_rot[i] + 100 * dt)));
                end
            end
            OP_READ: r = render_slot(int'(it.read_slot));
            default: r = '0;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: %h", o_result);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_result.slot_index !== e.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", e.slot_index,
                           o_result.slot_index);
                    fail_count++;
                end
                if (o_result.slot_active !== e.slot_active) begin
                    $error("slot_active: expected %0d, got %0d", e.slot_active,
                           o_result.slot_active);
                    fail_count++;
                end
                if (o_result.out_pos_x !== e.out_pos_x) begin
                    $error("out_pos_x: expected %h, got %h", e.out_pos_x, o_result.out_pos_x);
                    fail_count++;
                end
                if (o_result.out_pos_y !== e.out_pos_y) begin
                    $error("out_pos_y: expected %h, got %h", e.out_pos_y, o_result.out_pos_y);
                    fail_count++;
                end
                if (o_result.out_rotation !== e.out_rotation) begin
                    $error("out_rotation: expected %h, got %h", e.out_rotation,
                           o_result.out_rotation);
                    fail_count++;
                end
                if (o_result.out_size !== e.out_size) begin
                    $error("out_size: expected %h, got %h", e.out_size, o_result.out_size);
                    fail_count++;
                end
                if (o_result.out_colour !== e.out_colour) begin
                    $error("out_colour: expected %h, got %h", e.out_colour,
                           o_result.out_colour);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // one item beat; start stays high afterwards only when hold is set
    task automatic send_item(t_in it, bit hold);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(pool_result(it));
        if (!hold) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        wait (expected_results.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_val[idx] = (idx == CFG_SCOL || idx == CFG_FCOL) ? data : data & 32'h7fffffff;
    endtask

    task automatic write_all_regs(logic [31:0] vjx, logic [31:0] vjy, logic [31:0] sj,
                                  logic [31:0] ss, logic [31:0] fs, logic [31:0] sc,
                                  logic [31:0] fc, logic [31:0] life);
        drain();
        write_reg(CFG_VJX, vjx);
        write_reg(CFG_VJY, vjy);
        write_reg(CFG_SJ, sj);
        write_reg(CFG_SSIZE, ss);
        write_reg(CFG_FSIZE, fs);
        write_reg(CFG_SCOL, sc);
        write_reg(CFG_FCOL, fc);
        write_reg(CFG_LIFE, life);
    endtask

    function automatic logic [31:0] rand_q16();
        return ($urandom_range(0, 1) == 1) ? 32'($urandom)
                                           : 32'($signed(32'($urandom_range(0, 20'hfffff)))
                                                 - 32'sh80000);
    endfunction

    function automatic t_in rand_item(logic [1:0] op);
        t_in it;
        it.op           = op;
        it.pos_x        = rand_q16();
        it.pos_y        = rand_q16();
        it.vel_x        = rand_q16();
        it.vel_y        = rand_q16();
        it.delta_time   = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                      : 31'($urandom_range(0, 20000));
        it.rnd_rotation = 16'($urandom);
        it.rnd_vel_x    = 16'($urandom);
        it.rnd_vel_y    = 16'($urandom);
        it.rnd_size     = 16'($urandom);
        it.read_slot    = 10'($urandom);
        // reads only go to slots that hold data
        if (op == OP_READ && !slot_written[it.read_slot]) it.read_slot = 10'(last_emitted);
        return it;
    endfunction

    task automatic test_basic_ops();
        t_in it;
        it = rand_item(OP_EMIT);
        it.rnd_rotation = 16'h0000;
        send_item(it, 1);
        it = rand_item(OP_EMIT);
        it.rnd_rotation = 16'hffff;
        send_item(it, 0);
        it = rand_item(OP_READ);
        it.read_slot = 10'(POOL_SIZE - 1);
        send_item(it, 1);
        it = rand_item(OP_TICK);
        it.delta_time = '0;
        send_item(it, 0);
        it = rand_item(OP_TICK);
        it.delta_time = 31'd16384;
        send_item(it, 1);
        send_item(rand_item(OP_UNDEF), 0);
        it = rand_item(OP_READ);
        it.read_slot = 10'(POOL_SIZE - 2);
        send_item(it, 0);
    endtask

    task automatic test_field_extremes();
        t_in it;
        write_all_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h00000000, 32'hffffffff, 32'h7fffffff);
        for (int k = 0; k < 4; k++) begin
            it = rand_item(OP_EMIT);
            it.pos_x     = k[0] ? 32'sh7fffffff : 32'sh80000000;
            it.pos_y     = k[0] ? 32'sh80000000 : 32'sh7fffffff;
            it.vel_x     = k[1] ? 32'sh7fffffff : 32'sh80000000;
            it.vel_y     = k[1] ? 32'sh80000000 : 32'sh7fffffff;
            it.rnd_vel_x = k[1] ? 16'hffff : 16'h0000;
            it.rnd_vel_y = k[1] ? 16'h0000 : 16'hffff;
            it.rnd_size  = k[0] ? 16'hffff : 16'h0000;
            send_item(it, k != 3);
        end
        // saturating moves and wrapping rotation
        it = rand_item(OP_TICK);
        it.delta_time = 31'h7fffffff;
        send_item(it, 0);
        it = rand_item(OP_READ);
        it.read_slot = 10'(last_emitted);
        send_item(it, 0);
    endtask

    task automatic test_zero_life();
        t_in it;
        write_all_regs(32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'h11223344,
                       32'hccddeeff, 32'd0);
        send_item(rand_item(OP_EMIT), 0);
        it = rand_item(OP_TICK);
        it.delta_time = 31'd100;
        send_item(it, 0);
        // retired slot still reports its stored values
        it = rand_item(OP_READ);
        it.read_slot = 10'(last_emitted);
        send_item(it, 0);
    endtask

    task automatic test_random_phases();
        int          burst;
        int          pick;
        logic [1:0]  op;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0)
                write_all_regs(32'd0, 32'd0, 32'd0, 32'd32768, 32'd0, 32'hffffffff,
                               32'd0, 32'd65536);
            else
                write_all_regs($urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
                               $urandom_range(0, 32'h20000), $urandom_range(0, 32'h40000),
                               $urandom_range(0, 32'h40000), $urandom, $urandom,
                               $urandom_range(1, 32'h30000));
            burst = 0;
            for (int n = 0; n < 150; n++) begin
                pick = $urandom_range(0, 99);
                op = (pick < 45) ? OP_EMIT : (pick < 82) ? OP_READ :
                     (pick < 97) ? OP_TICK : OP_UNDEF;
                if (burst == 0) burst = $urandom_range(1, 12);
                burst--;
                // start drops after the last beat of a phase
                send_item(rand_item(op), (burst != 0) && (n < 149));
                // gaps between bursts, none at all in the later half of the second phase
                if (burst == 0 && !(phase == 1 && n > 75))
                    repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        fail_count  = 0;
        cycle_count = 0;
        ring_slot    = POOL_SIZE - 1;
        last_emitted = POOL_SIZE - 1;
        reg_val = '{32'd0, 32'd0, 32'd0, 32'd32768, 32'd0, 32'hffffffff, 32'd0, 32'd65536};
        for (int i = 0; i < POOL_SIZE; i++) begin
            slot_live[i]    = 1'b0;
            slot_written[i] = 1'b0;
            slot_px[i] = 0; slot_py[i] = 0; slot_vx[i] = 0; slot_vy[i] = 0;
            slot_rot[i] = 0; slot_rem[i] = 0; slot_full[i] = 0;
            slot_bsize[i] = 0; slot_dsize[i] = 0; slot_bcol[i] = 0; slot_dcol[i] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_field_extremes();
        test_zero_life();
        test_random_phases();

        wait (expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ppe_pkg.sv
design/ppe_divider.sv
design/ppe_ctrl.sv
design/ppe_datapath.sv
design/particle_pool_engine.sv
tb/sv/testbench.sv
